### src/stp_pkg.sv
package stp_pkg;
  localparam int unsigned BlankTicks = 5;
  localparam int unsigned TickRate = 5000;
  localparam int unsigned AccelCap = 32500;
  localparam int unsigned StopEps = 10;

  // TickRate is 8 * 625, so x / TickRate == ((x >> 3) * Recip625) >> RecipShift
  // holds exactly for every 32-bit x.
  localparam logic [31:0] Recip625 = 32'd879609303;
  localparam int unsigned RecipShift = 39;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_VEL  = 3'd1;
  localparam logic [2:0] KIND_MOVE = 3'd2;
  localparam logic [2:0] KIND_STOP = 3'd3;
  localparam logic [2:0] KIND_POLL = 3'd4;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_VEL    = 3'd1;
  localparam logic [2:0] MODE_ACCEL  = 3'd2;
  localparam logic [2:0] MODE_CRUISE = 3'd3;
  localparam logic [2:0] MODE_DECEL  = 3'd4;

  localparam logic REG_MAX_RATE = 1'b0;
  localparam logic REG_WIDE     = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic signed [15:0] target_rate;
    logic [15:0] accel_limit;
    logic signed [15:0] step_count;
    logic [31:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic [14:0] step_rate;
    logic        rate_changed;
    logic        direction;
    logic signed [31:0] position;
    logic signed [15:0] velocity;
    logic        busy_res;
    logic [2:0]  mode;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;
endpackage

### src/stp_if.sv
interface stp_in_if;
  import stp_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface stp_out_if;
  import stp_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### src/stp_div.sv
module stp_div (
  input  logic clk,
  input  logic rst,
  input  stp_pkg::div_req_t req,
  output logic busy,
  output logic [63:0] quo
);
  import stp_pkg::*;
  logic [63:0] rem;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic [64:0] trial;

  // Restoring divider, one quotient bit per cycle.
  always_comb begin
    trial = {rem[63:0], quo[63]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

### src/stepper_trapezoid_profile.sv
// Channel   Dir  Payload
// in_ch     in   kind, target_rate, accel_limit, step_count, counter_value
// out_ch    out  step_rate, rate_changed, direction, position, velocity, busy_res, mode
// cfg       in   cfg_we, cfg_idx, cfg_data (max_rate, counter_is_wide)
// A profile tick runs from its accept to its result beat through S_STEP, S_DIST and S_SQR
// on the shared multiplier (accel/5000 and speed/5000 by reciprocal, then v*v), the
// 64-step serial divider for v*v/2a, then update, rate refresh and the result beat.
// With zero acceleration the divider is skipped. A blanked tick goes straight to the
// result beat, every other kind through S_CMD first. Reset is synchronous; the block takes no item while
// one is in work or while the result beat waits on out_ch.ready.
module stepper_trapezoid_profile (
  input  logic clk,
  input  logic rst,
  stp_in_if.sink    in_ch,
  stp_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [14:0] cfg_data
);
  import stp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_STEP, S_DIST, S_SQR, S_WAIT_B, S_APPLY, S_RATE, S_OUT
  } state_t;

  state_t state;
  logic [14:0] max_rate;
  logic wide;
  logic [31:0] speed_now, speed_goal, accel_fixed, spd_rev, pos, steps_left, planned, prev;
  logic dir_now, dir_wanted;
  logic [2:0] blank_left, mmode;
  logic [15:0] sent_rate;
  logic changed;
  in_item_t it;
  logic [31:0] step_q, d_q;
  logic [63:0] brake;
  div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;

  stp_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quo(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate <= 15'h7FFF;
      wide <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_RATE: max_rate <= cfg_data;
        REG_WIDE:     wide <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign out_ch.valid = (state == S_OUT);

  logic [15:0] sp16;
  assign sp16 = speed_now[31:16];
  always_comb begin
    out_ch.data.step_rate = sent_rate[14:0];
    out_ch.data.rate_changed = changed;
    out_ch.data.direction = dir_now;
    out_ch.data.position = pos;
    out_ch.data.velocity = dir_now ? (16'd0 - sp16) : sp16;
    out_ch.data.busy_res = (mmode != MODE_IDLE) || (sp16 != 16'd0);
    out_ch.data.mode = mmode;
  end

  // One multiplier serves both divisions by the tick rate and the v*v product.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] recip_q;
  always_comb begin
    if (state == S_STEP) begin
      mul_a = {3'd0, accel_fixed[31:3]};
      mul_b = Recip625;
    end else if (state == S_DIST) begin
      mul_a = {3'd0, speed_now[31:3]};
      mul_b = Recip625;
    end else begin
      mul_a = speed_now;
      mul_b = speed_now;
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
    recip_q = 32'(mul_p >> RecipShift);
  end

  // Non-tick items, combinational on the captured beat.
  logic signed [16:0] rate17, mag_v, peak;
  logic signed [16:0] stp17, mag_s;
  logic [31:0] acc_ld;
  logic [31:0] raw;
  logic signed [32:0] delta;
  logic [32:0] absd;
  logic signed [33:0] rleft;
  always_comb begin
    rate17 = 17'(it.target_rate);
    mag_v = rate17[16] ? -rate17 : rate17;
    if (mag_v > $signed({2'b0, max_rate})) mag_v = $signed({2'b0, max_rate});
    peak = (rate17 > $signed({2'b0, max_rate})) ? $signed({2'b0, max_rate}) : rate17;
    stp17 = 17'(it.step_count);
    mag_s = stp17[16] ? -stp17 : stp17;
    acc_ld = (it.accel_limit > 16'(AccelCap)) ? {16'(AccelCap), 16'd0}
                                                : {it.accel_limit, 16'd0};
    raw = it.counter_value - prev;
    delta = 33'($signed(raw));
    if (!wide) begin
      if (delta > 33'sd32767) delta = delta - 33'sd65536;
      else if (delta < -33'sd32767) delta = delta + 33'sd65536;
    end
    absd = delta[32] ? 33'(-delta) : 33'(delta);
    rleft = $signed({2'b0, steps_left}) - $signed({1'b0, absd});
  end

  // Tick arithmetic after the divider results are in.
  logic [32:0] sum;
  logic [31:0] pl_new;
  always_comb begin
    sum = {1'b0, speed_now} + {1'b0, step_q};
    pl_new = (speed_now != 0) ? ((planned > d_q) ? planned - d_q : 32'd0) : planned;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dreq.start <= 1'b0;
      speed_now <= '0; speed_goal <= '0; accel_fixed <= '0; spd_rev <= '0;
      dir_now <= 1'b0; dir_wanted <= 1'b0; blank_left <= '0; pos <= '0;
      steps_left <= '0; planned <= '0; prev <= '0; sent_rate <= '0;
      mmode <= MODE_IDLE; changed <= 1'b0;
    end else begin
      dreq.start <= (state == S_SQR) && (accel_fixed != 0);
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          it <= in_ch.data;
          changed <= 1'b0;
          if (in_ch.data.kind != KIND_TICK) begin
            state <= S_CMD;
          end else if (blank_left != 0) begin
            blank_left <= blank_left - 3'd1;
            state <= S_OUT;
          end else begin
            if (dir_wanted != dir_now && sp16 == 0) begin
              dir_now <= dir_wanted;
              blank_left <= 3'(BlankTicks);
              if (spd_rev != 0) begin
                speed_goal <= spd_rev;
                spd_rev <= '0;
              end
            end
            state <= S_STEP;
          end
        end
        S_CMD: begin
          state <= S_OUT;
          unique case (it.kind)
            KIND_VEL: begin
              accel_fixed <= acc_ld;
              mmode <= MODE_VEL;
              if (rate17[16] != dir_now && sp16 != 0) begin
                // Still moving the other way: ramp to zero first.
                speed_goal <= '0;
                if (mag_v > $signed(17'(StopEps))) begin
                  dir_wanted <= rate17[16];
                  spd_rev <= {mag_v[15:0], 16'd0};
                end else begin
                  spd_rev <= '0;
                end
              end else begin
                speed_goal <= {mag_v[15:0], 16'd0};
                spd_rev <= '0;
                if (rate17[16] != dir_now) begin
                  dir_now <= rate17[16]; dir_wanted <= rate17[16];
                  blank_left <= 3'(BlankTicks);
                end
              end
            end
            KIND_MOVE: if (stp17 != 0) begin
              steps_left <= 32'(mag_s);
              planned <= {mag_s[15:0], 16'd0};
              accel_fixed <= acc_ld;
              mmode <= MODE_ACCEL;
              if (stp17[16] != dir_now && sp16 != 0) begin
                dir_wanted <= stp17[16];
                speed_goal <= '0;
              end else begin
                speed_goal <= {peak[15:0], 16'd0};
                if (stp17[16] != dir_now) begin
                  dir_now <= stp17[16]; dir_wanted <= stp17[16];
                  blank_left <= 3'(BlankTicks);
                end
              end
            end
            KIND_STOP: begin
              speed_goal <= '0; mmode <= MODE_VEL; steps_left <= '0; planned <= '0;
            end
            KIND_POLL: begin
              pos <= dir_now ? pos - delta[31:0] : pos + delta[31:0];
              if (mmode >= MODE_ACCEL && mmode <= MODE_DECEL)
                steps_left <= rleft[33] ? 32'd0 : rleft[31:0];
              prev <= it.counter_value;
            end
            default: ;
          endcase
        end
        S_STEP: begin
          step_q <= recip_q;
          state <= S_DIST;
        end
        S_DIST: begin
          d_q <= recip_q;
          state <= S_SQR;
        end
        S_SQR: begin
          if (accel_fixed != 0) begin
            dreq.dividend <= mul_p;
            dreq.divisor <= {31'd0, accel_fixed, 1'b0};
            state <= S_WAIT_B;
          end else begin
            brake <= '0;
            state <= S_APPLY;
          end
        end
        S_WAIT_B: if (!dreq.start && !dbusy) begin
          brake <= dq;
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_RATE;
          if (mmode == MODE_VEL) begin
            if ($signed({1'b0, speed_now}) < $signed({speed_goal[31], speed_goal})) begin
              if ($signed(sum) > $signed({speed_goal[31], speed_goal})) speed_now <= speed_goal;
              else speed_now <= sum[31:0];
              if (speed_goal == 0 && sum[31:0] == 0) mmode <= MODE_IDLE;
            end else if ($signed({1'b0, speed_now}) > $signed({speed_goal[31], speed_goal})) begin
              if (speed_goal[31] ? (speed_now <= step_q) :
                  ({1'b0, speed_now} <= {1'b0, speed_goal} + {1'b0, step_q})) begin
                speed_now <= speed_goal[31] ? 32'd0 : speed_goal;
                if (speed_goal == 0) mmode <= MODE_IDLE;
              end else speed_now <= speed_now - step_q;
            end else if (speed_goal == 0 && speed_now == 0) mmode <= MODE_IDLE;
          end else if (mmode >= MODE_ACCEL && mmode <= MODE_DECEL) begin
            if (steps_left == 0 || steps_left[31]) begin
              speed_now <= '0; speed_goal <= '0; planned <= '0; mmode <= MODE_IDLE;
            end else begin
              planned <= pl_new;
              if (mmode == MODE_ACCEL) begin
                if (brake >= {32'd0, pl_new}) mmode <= MODE_DECEL;
                else if ($signed({1'b0, speed_now}) >= $signed({speed_goal[31], speed_goal}))
                  mmode <= MODE_CRUISE;
                else if ($signed(sum) > $signed({speed_goal[31], speed_goal}))
                  speed_now <= speed_goal;
                else speed_now <= sum[31:0];
              end else if (mmode == MODE_CRUISE) begin
                if (brake >= {32'd0, pl_new}) mmode <= MODE_DECEL;
              end else begin
                speed_now <= (speed_now > step_q) ? speed_now - step_q : 32'd0;
              end
            end
          end
        end
        S_RATE: begin
          // Refresh the step generator rate from the updated speed.
          if (sp16 != sent_rate) begin
            sent_rate <= sp16;
            changed <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### verif/stepper_trapezoid_profile_test.sv
module stepper_trapezoid_profile_test;
  import stp_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned RandomItems = 850;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic        cfg_idx;
  logic [14:0] cfg_data;

  stp_in_if  in_ch();
  stp_out_if out_ch();

  stepper_trapezoid_profile dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  // Profiler state mirrored for prediction.
  logic [31:0]        speed_q;
  logic signed [31:0] goal_q;
  logic [31:0]        accel_q;
  logic [31:0]        resume_q;
  logic               dir_q;
  logic               dir_wait_q;
  logic [2:0]         blank_q;
  logic [31:0]        pos_q;
  logic signed [31:0] left_q;
  logic [31:0]        plan_q;
  logic [31:0]        prev_cnt_q;
  logic [15:0]        sent_q;
  logic [2:0]         mode_q;
  logic [14:0]        rate_cap;
  logic               wide_cnt;

  out_item_t status_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit idle_on;
  logic [31:0] counter_base;

  function automatic logic [31:0] cap_accel(logic [15:0] a);
    logic [31:0] v;
    v = (a > AccelCap) ? AccelCap : a;
    return v << 16;
  endfunction

  function automatic void flip_dir(logic d);
    if (d != dir_q) begin
      dir_q = d;
      dir_wait_q = d;
      blank_q = 3'(BlankTicks);
    end
  endfunction

  function automatic void ramp_velocity();
    longint stp, now, goal, low;
    stp = accel_q / TickRate;
    now = speed_q;
    goal = goal_q;
    if (now < goal) begin
      now += stp;
      if (now > goal) now = goal;
    end else if (now > goal) begin
      low = (goal < 0) ? 0 : goal;
      now -= stp;
      if (now < low) now = low;
    end
    speed_q = now[31:0];
    if (goal_q == 0 && speed_q == 0) mode_q = MODE_IDLE;
  endfunction

  function automatic void ramp_move();
    logic [31:0] stp, d;
    longint unsigned brake;
    longint now;
    stp = accel_q / TickRate;
    brake = 0;
    if (left_q <= 0) begin
      speed_q = 0;
      goal_q = 0;
      plan_q = 0;
      mode_q = MODE_IDLE;
      return;
    end
    if (speed_q > 0) begin
      d = speed_q / TickRate;
      plan_q = (plan_q > d) ? plan_q - d : 0;
    end
    if (accel_q > 0)
      brake = (longint'(speed_q) * longint'(speed_q)) / (2 * longint'(accel_q));
    if (mode_q == MODE_ACCEL) begin
      if (brake >= plan_q) begin
        mode_q = MODE_DECEL;
      end else if (longint'(speed_q) >= longint'(goal_q)) begin
        mode_q = MODE_CRUISE;
      end else begin
        now = longint'(speed_q) + longint'(stp);
        if (now > longint'(goal_q)) now = goal_q;
        speed_q = now[31:0];
      end
    end else if (mode_q == MODE_CRUISE) begin
      if (brake >= plan_q) mode_q = MODE_DECEL;
    end else begin
      speed_q = (speed_q > stp) ? speed_q - stp : 0;
    end
  endfunction

  function automatic out_item_t profile_step(in_item_t it);
    out_item_t r;
    int mag, peak;
    logic want_dir, changed;
    logic [31:0] raw;
    logic [15:0] sp;
    longint delta, rem;
    changed = 0;
    case (it.kind)
      KIND_TICK: begin
        if (blank_q > 0) begin
          blank_q--;
        end else begin
          if (dir_wait_q != dir_q && speed_q[31:16] == 0) begin
            flip_dir(dir_wait_q);
            if (resume_q > 0) begin
              goal_q = resume_q;
              resume_q = 0;
            end
          end
          if (mode_q == MODE_VEL) ramp_velocity();
          else if (mode_q >= MODE_ACCEL && mode_q <= MODE_DECEL) ramp_move();
          if (speed_q[31:16] != sent_q) begin
            sent_q = speed_q[31:16];
            changed = 1;
          end
        end
      end
      KIND_VEL: begin
        mag = (it.target_rate < 0) ? -int'(it.target_rate) : int'(it.target_rate);
        want_dir = (it.target_rate < 0);
        if (mag > int'(rate_cap)) mag = rate_cap;
        goal_q = mag << 16;
        accel_q = cap_accel(it.accel_limit);
        mode_q = MODE_VEL;
        resume_q = 0;
        if (want_dir != dir_q) begin
          if (speed_q[31:16] == 0) begin
            flip_dir(want_dir);
          end else if (mag <= StopEps) begin
            goal_q = 0;
          end else begin
            dir_wait_q = want_dir;
            resume_q = mag << 16;
            goal_q = 0;
          end
        end
      end
      KIND_MOVE: begin
        if (it.step_count != 0) begin
          mag = (it.step_count < 0) ? -int'(it.step_count) : int'(it.step_count);
          want_dir = (it.step_count < 0);
          peak = (int'(it.target_rate) > int'(rate_cap)) ? int'(rate_cap)
                                                         : int'(it.target_rate);
          left_q = mag;
          plan_q = mag << 16;
          goal_q = peak * 65536;
          accel_q = cap_accel(it.accel_limit);
          mode_q = MODE_ACCEL;
          if (want_dir != dir_q) begin
            if (speed_q[31:16] == 0) begin
              flip_dir(want_dir);
            end else begin
              dir_wait_q = want_dir;
              goal_q = 0;
            end
          end
        end
      end
      KIND_STOP: begin
        goal_q = 0;
        mode_q = MODE_VEL;
        left_q = 0;
        plan_q = 0;
      end
      KIND_POLL: begin
        raw = it.counter_value - prev_cnt_q;
        delta = longint'($signed(raw));
        if (!wide_cnt) begin
          if (delta > 32767) delta -= 65536;
          else if (delta < -32767) delta += 65536;
        end
        if (dir_q) pos_q = pos_q - delta[31:0];
        else pos_q = pos_q + delta[31:0];
        if (mode_q >= MODE_ACCEL && mode_q <= MODE_DECEL) begin
          rem = longint'(left_q) - ((delta < 0) ? -delta : delta);
          left_q = (rem < 0) ? 0 : rem[31:0];
        end
        prev_cnt_q = it.counter_value;
      end
      default: ;
    endcase
    sp = speed_q[31:16];
    r.step_rate = sent_q[14:0];
    r.rate_changed = changed;
    r.direction = dir_q;
    r.position = pos_q;
    r.velocity = dir_q ? -sp : sp;
    r.busy_res = (mode_q != MODE_IDLE) || (sp != 0);
    r.mode = mode_q;
    return r;
  endfunction

  function automatic in_item_t mk(logic [2:0] k, logic signed [15:0] rt, logic [15:0] ac,
                                  logic signed [15:0] st, logic [31:0] cv);
    in_item_t it;
    it.kind = k;
    it.target_rate = rt;
    it.accel_limit = ac;
    it.step_count = st;
    it.counter_value = cv;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return mk(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
              $urandom);
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: sample at the rising edge, move ready at the falling edge.
  initial begin
    int unsigned hold;
    out_item_t want, got;
    hold = 0;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
        end else begin
          want = status_due.pop_front();
          if (got.step_rate !== want.step_rate || got.rate_changed !== want.rate_changed ||
              got.direction !== want.direction || got.position !== want.position ||
              got.velocity !== want.velocity || got.busy_res !== want.busy_res ||
              got.mode !== want.mode) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result mismatch, expected %p, got %p", want, got);
          end
        end
      end
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 0;
        hold = $urandom_range(1, 17) - 1;
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    status_due.push_back(profile_step(it));
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_MAX_RATE) rate_cap = val;
    else wide_cnt = val[0];
  endtask

  // Well-formed motion sequences with random content, plus some noise.
  task automatic random_burst(ref int unsigned sent);
    int unsigned n, pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_item(mk(KIND_VEL,
                   16'($signed($urandom_range(0, 400)) * ($urandom_range(0, 1) ? 1 : -1)),
                   16'($urandom), 16'($urandom), $urandom));
      n = $urandom_range(5, 40);
      repeat (n) send_item(mk(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom));
      sent += n + 1;
    end else if (pick < 8) begin
      send_item(mk(KIND_MOVE, 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 1) ? $urandom_range(20000, 65535) : $urandom),
                   16'($signed($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1)),
                   $urandom));
      n = $urandom_range(10, 50);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          counter_base += $urandom_range(0, 12);
          send_item(mk(KIND_POLL, 16'($urandom), 16'($urandom), 16'($urandom),
                       counter_base));
        end else begin
          send_item(mk(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), $urandom));
        end
      end
      sent += n + 1;
    end else if (pick == 8) begin
      send_item(mk(KIND_STOP, 16'($urandom), 16'($urandom), 16'($urandom), $urandom));
      sent++;
    end else begin
      counter_base = $urandom;
      send_item(noise_item());
      sent++;
    end
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int unsigned sent;
    logic [14:0] caps[5];
    logic        wides[5];

    caps = '{15'd32767, 15'd0, 15'd150, 15'd32767, 15'd1};
    wides = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    rst = 1;
    cfg_we = 0;
    cfg_idx = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    idle_on = 1;
    counter_base = 0;
    speed_q = 0; goal_q = 0; accel_q = 0; resume_q = 0;
    dir_q = 0; dir_wait_q = 0; blank_q = 0; pos_q = 0;
    left_q = 0; plan_q = 0; prev_cnt_q = 0; sent_q = 0; mode_q = MODE_IDLE;
    rate_cap = 15'd32767;
    wide_cnt = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed rows: after reset, unknown kinds, extremes, reversal, moves, stop.
    row.fixed = 1;
    row.want = '0;
    row.item = mk(KIND_TICK, 0, 0, 0, 0);             rows.push_back(row);
    row.item = mk(3'd7, 16'sh7fff, 16'hffff, 16'sh7fff, 32'hffffffff); rows.push_back(row);
    row.item = mk(3'd5, -16'sd32767, 0, -16'sd32767, 0); rows.push_back(row);
    row.item = mk(KIND_POLL, 0, 0, 0, 5);
    row.want.position = 5;                            rows.push_back(row);
    row.fixed = 0;
    row.item = mk(KIND_POLL, 0, 0, 0, 32'hffff0000);  rows.push_back(row);
    row.item = mk(KIND_POLL, 0, 0, 0, 32'hffffffff);  rows.push_back(row);
    row.item = mk(KIND_VEL, 16'sd200, 16'hffff, 0, 0); rows.push_back(row);
    repeat (6) begin row.item = mk(KIND_TICK, 0, 0, 0, 0); rows.push_back(row); end
    row.item = mk(KIND_VEL, -16'sd200, 16'd32500, 0, 0); rows.push_back(row);
    row.item = mk(KIND_VEL, -16'sd5, 16'd32500, 0, 0); rows.push_back(row);
    row.item = mk(KIND_STOP, 0, 0, 0, 0);             rows.push_back(row);
    row.item = mk(KIND_MOVE, 16'sd50, 16'd30000, 16'sd0, 0); rows.push_back(row);
    row.item = mk(KIND_MOVE, -16'sd5, 16'd1000, 16'sd40, 0); rows.push_back(row);
    row.item = mk(KIND_MOVE, 16'sh7fff, 16'hffff, -16'sd32767, 0); rows.push_back(row);
    row.item = mk(KIND_VEL, 16'sh7fff, 0, 0, 0);      rows.push_back(row);
    row.item = mk(KIND_VEL, -16'sd32767, 16'hffff, 0, 0); rows.push_back(row);
    repeat (3) begin row.item = mk(KIND_TICK, 0, 0, 0, 0); rows.push_back(row); end

    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].fixed) begin
        void'(status_due.pop_back());
        status_due.push_back(rows[i].want);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      // Every phase boundary also holds the sender off until all results are in.
      settle();
      if (ph == 4) idle_on = 0;
      write_reg(REG_MAX_RATE, caps[ph]);
      write_reg(REG_WIDE, {14'd0, wides[ph]});
      sent = 0;
      counter_base = prev_cnt_q;
      while (sent < RandomItems / 5) random_burst(sent);
    end

    @(negedge clk);
    in_ch.valid = 0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sim.f
src/stp_pkg.sv
src/stp_if.sv
src/stp_div.sv
src/stepper_trapezoid_profile.sv
verif/stepper_trapezoid_profile_test.sv
